// ===== src/glsc_pkg.sv =====
// Shared types and constants for the grid line spacing classifier.
// Used by glsc_ctrl, glsc_dp and grid_line_spacing_classifier_top.
`timescale 1ns / 1ps
`default_nettype none
package glsc_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned CountW    = $clog2(MaxPoints + 2);
  localparam int unsigned WinGaps   = 9;

  localparam logic [CountW-1:0] NPT_MAX = CountW'(MaxPoints);
  localparam logic [CountW-1:0] NWIN    = CountW'(WinGaps);
  localparam logic [3:0]        LAST_GRP = 4'(WinGaps);

  localparam logic [15:0] MIN_SPACING_RST = 16'd320;
  localparam logic [5:0]  MAX_RATIO_RST   = 6'd13;

  localparam logic CFG_MIN_SPACING = 1'b0;
  localparam logic CFG_MAX_RATIO   = 1'b1;

  typedef struct packed {
    logic [15:0] pos;
    logic [7:0]  id;
  } pt_t;

  typedef struct packed {
    logic [15:0] size;
    logic [7:0]  lid;
    logic [7:0]  rid;
    logic [15:0] at;
  } gap_t;

  typedef struct packed {
    logic             p_we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] ra;
    logic [AddrW-1:0] rb;
    logic             gap_phase;
    logic             rank_clr;
    logic             cmp_en;
    logic [AddrW-1:0] cmp_idx;
    logic [AddrW-1:0] cmp_i;
    logic             s_we;
    logic             g_we;
    logic             win_clr;
    logic             win_en;
    logic [AddrW-1:0] win_idx;
    logic             sel_clr;
    logic             sel_en;
    logic [3:0]       grp;
    logic             sub;
    logic             emit_ld;
    logic             grp_adv;
    logic             fail_ld;
  } cmd_t;

  typedef struct packed {
    logic             have;
    logic             ratio_ok;
    logic [AddrW-1:0] best;
    logic             out_free;
    logic             two;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/glsc_ctrl.sv =====
// Controller state machine: load, sort, gap, window search, check, select, emit and fail phases.
// Depends on glsc_pkg; drives glsc_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none
module glsc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          last,
  output logic               in_stall,
  output glsc_pkg::cmd_t     cmd,
  input  wire glsc_pkg::sts_t sts
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SP   = 9'b000000010,
    ST_GAP  = 9'b000000100,
    ST_SG   = 9'b000001000,
    ST_WIN  = 9'b000010000,
    ST_CHK  = 9'b000100000,
    ST_SEL  = 9'b001000000,
    ST_EMIT = 9'b010000000,
    ST_FAIL = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [glsc_pkg::CountW-1:0] cnt, cnt_next, n, n_next, i, i_next, k, k_next;
  logic sub, sub_next;
  logic [glsc_pkg::CountW-1:0] lim;
  logic [glsc_pkg::AddrW-1:0] k6;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      n     <= '0;
      i     <= '0;
      k     <= '0;
      sub   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      n     <= n_next;
      i     <= i_next;
      k     <= k_next;
      sub   <= sub_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    n_next     = n;
    i_next     = i;
    k_next     = k;
    sub_next   = sub;
    cmd        = '0;
    k6         = k[glsc_pkg::AddrW-1:0];
    lim        = (state == ST_SG) ? (n - 1'b1) : n;
    cmd.cmp_idx = k6 - 1'b1;
    cmd.cmp_i   = i[glsc_pkg::AddrW-1:0];
    cmd.win_idx = k6 - 1'b1;
    cmd.grp     = k[3:0];
    cmd.sub     = sub;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cnt < glsc_pkg::NPT_MAX) begin
            cmd.p_we  = 1'b1;
            cmd.waddr = cnt[glsc_pkg::AddrW-1:0];
            cnt_next  = cnt + 1'b1;
          end
          if (last) begin
            n_next   = (cnt < glsc_pkg::NPT_MAX) ? cnt + 1'b1 : cnt;
            cnt_next = '0;
            i_next   = '0;
            k_next   = '0;
            state_next = (n_next <= glsc_pkg::NWIN) ? ST_FAIL : ST_SP;
          end
        end
      end
      ST_SP, ST_SG: begin
        cmd.gap_phase = (state == ST_SG);
        cmd.ra = i[glsc_pkg::AddrW-1:0];
        cmd.rb = k6;
        cmd.rank_clr = (k == '0);
        cmd.cmp_en = (k != '0) && (k <= lim);
        if (k == lim + 1'b1) begin
          cmd.s_we = 1'b1;
          k_next = '0;
          if (i == lim - 1'b1) begin
            i_next = '0;
            state_next = (state == ST_SP) ? ST_GAP : ST_WIN;
          end else begin
            i_next = i + 1'b1;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_GAP: begin
        cmd.ra = k6;
        cmd.rb = k6 + 1'b1;
        cmd.waddr = k6 - 1'b1;
        cmd.g_we = (k != '0);
        if (k == n - 1'b1) begin
          k_next = '0;
          i_next = '0;
          state_next = ST_SG;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_WIN: begin
        cmd.gap_phase = 1'b1;
        cmd.ra = k6;
        cmd.rb = k6 + glsc_pkg::AddrW'(glsc_pkg::WinGaps - 1);
        cmd.win_clr = (k == '0);
        cmd.win_en = (k != '0);
        if (k == n - glsc_pkg::NWIN) begin
          k_next = '0;
          state_next = ST_CHK;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_CHK: begin
        k_next = '0;
        state_next = (sts.have && sts.ratio_ok) ? ST_SEL : ST_FAIL;
      end
      ST_SEL: begin
        cmd.ra = sts.best + k6;
        cmd.sel_clr = (k == '0);
        cmd.sel_en = (k != '0);
        if (k == glsc_pkg::NWIN) begin
          k_next = '0;
          sub_next = 1'b0;
          state_next = ST_EMIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          if (!sub && sts.two) begin
            sub_next = 1'b1;
          end else begin
            sub_next = 1'b0;
            cmd.grp_adv = 1'b1;
            k_next = k + 1'b1;
            if (k[3:0] == glsc_pkg::LAST_GRP) begin
              k_next = '0;
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_FAIL: begin
        if (sts.out_free) begin
          cmd.fail_ld = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/glsc_dp.sv =====
// Datapath: point and gap memories, rank counter, window search, selection and output.
// Depends on glsc_pkg; sequenced by glsc_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module glsc_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire glsc_pkg::cmd_t cmd,
  output glsc_pkg::sts_t      sts,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [15:0]    cfg_data,
  input  wire logic [15:0]    position,
  input  wire logic [7:0]     line_id,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                found,
  output logic [3:0]          group,
  output logic [7:0]          member_id,
  output logic                final_res
);

  localparam int unsigned W = glsc_pkg::WinGaps;

  glsc_pkg::pt_t  mem_p [glsc_pkg::MaxPoints];
  glsc_pkg::pt_t  mem_s [glsc_pkg::MaxPoints];
  glsc_pkg::gap_t mem_g [glsc_pkg::MaxPoints];
  glsc_pkg::gap_t mem_h [glsc_pkg::MaxPoints];
  glsc_pkg::pt_t  pa_q, pb_q, sa_q, sb_q;
  glsc_pkg::gap_t ga_q, gb_q, ha_q, hb_q;

  logic [15:0] min_spacing;
  logic [5:0]  max_ratio;
  logic [glsc_pkg::AddrW-1:0] rank;
  logic        less, key_lt, key_eq;
  glsc_pkg::gap_t gap_new;

  logic        have;
  logic [15:0] spread, blo, bhi;
  logic [glsc_pkg::AddrW-1:0] best;
  logic [15:0] wspread;
  logic [19:0] hi10;
  logic [21:0] lo_r;

  glsc_pkg::gap_t sel [W];
  glsc_pkg::gap_t sel_new [W];
  logic [W-1:0] le;
  logic [3:0]  m;
  logic [7:0]  prev_rid;
  logic        has_a, has_b, two;
  logic [7:0]  id_a, lo_id, hi_id;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_spacing <= glsc_pkg::MIN_SPACING_RST;
      max_ratio   <= glsc_pkg::MAX_RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glsc_pkg::CFG_MIN_SPACING: min_spacing <= cfg_data;
        glsc_pkg::CFG_MAX_RATIO:   max_ratio   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_we) mem_p[cmd.waddr] <= '{pos: position, id: line_id};
    pa_q <= mem_p[cmd.ra];
    pb_q <= mem_p[cmd.rb];
  end

  always_ff @(posedge clk) begin
    if (cmd.s_we && !cmd.gap_phase) mem_s[rank] <= pa_q;
    sa_q <= mem_s[cmd.ra];
    sb_q <= mem_s[cmd.rb];
  end

  always_comb begin
    gap_new.size = sb_q.pos - sa_q.pos;
    gap_new.lid  = sa_q.id;
    gap_new.rid  = sb_q.id;
    gap_new.at   = sb_q.pos;
  end

  always_ff @(posedge clk) begin
    if (cmd.g_we) mem_g[cmd.waddr] <= gap_new;
    ga_q <= mem_g[cmd.ra];
    gb_q <= mem_g[cmd.rb];
  end

  always_ff @(posedge clk) begin
    if (cmd.s_we && cmd.gap_phase) mem_h[rank] <= ga_q;
    ha_q <= mem_h[cmd.ra];
    hb_q <= mem_h[cmd.rb];
  end

  // Stable rank: earlier equal keys count as smaller.
  always_comb begin
    key_lt = cmd.gap_phase ? (gb_q.size < ga_q.size) : (pb_q.pos < pa_q.pos);
    key_eq = cmd.gap_phase ? (gb_q.size == ga_q.size) : (pb_q.pos == pa_q.pos);
    less   = key_lt || (key_eq && (cmd.cmp_idx < cmd.cmp_i));
  end

  always_ff @(posedge clk) begin
    if (cmd.rank_clr) rank <= '0;
    else if (cmd.cmp_en && less) rank <= rank + 1'b1;
  end

  // Window search over the sorted gaps.
  assign wspread = hb_q.size - ha_q.size;

  always_ff @(posedge clk) begin
    if (rst || cmd.win_clr) begin
      have <= 1'b0;
    end else if (cmd.win_en && (ha_q.size > min_spacing) && (!have || wspread < spread)) begin
      have   <= 1'b1;
      spread <= wspread;
      best   <= cmd.win_idx;
      blo    <= ha_q.size;
      bhi    <= hb_q.size;
    end
  end

  assign hi10 = {4'b0, bhi} * 20'd10;
  assign lo_r = {6'b0, blo} * {16'b0, max_ratio};

  // Insertion into the position-ordered selection, one gap a cycle.
  always_comb begin
    for (int j = 0; j < W; j++) begin
      le[j] = (4'(j) < m) && (sel[j].at <= ha_q.at);
    end
    sel_new[0] = le[0] ? sel[0] : ha_q;
    for (int j = 1; j < W; j++) begin
      if (le[j]) sel_new[j] = sel[j];
      else if (le[j-1]) sel_new[j] = ha_q;
      else sel_new[j] = sel[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_clr) begin
      m <= '0;
    end else if (cmd.sel_en) begin
      m <= m + 1'b1;
      for (int j = 0; j < W; j++) sel[j] <= sel_new[j];
    end else if (cmd.grp_adv) begin
      prev_rid <= sel[0].rid;
      for (int j = 0; j < W - 1; j++) sel[j] <= sel[j+1];
    end
  end

  // Members of the current group: left id of this gap, right id of the previous.
  always_comb begin
    has_a = (cmd.grp != glsc_pkg::LAST_GRP);
    has_b = (cmd.grp != 4'd0);
    id_a  = sel[0].lid;
    two   = has_a && has_b && (id_a != prev_rid);
    if (has_a && has_b) begin
      lo_id = (prev_rid < id_a) ? prev_rid : id_a;
      hi_id = (prev_rid < id_a) ? id_a : prev_rid;
    end else begin
      lo_id = has_a ? id_a : prev_rid;
      hi_id = lo_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
      found     <= 1'b1;
      group     <= cmd.grp;
      member_id <= cmd.sub ? hi_id : lo_id;
      final_res <= (cmd.grp == glsc_pkg::LAST_GRP);
    end else if (cmd.fail_ld) begin
      out_valid <= 1'b1;
      found     <= 1'b0;
      group     <= '0;
      member_id <= '0;
      final_res <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.have     = have;
    sts.ratio_ok = ({2'b0, hi10} <= lo_r);
    sts.best     = best;
    sts.out_free = !out_valid || !out_stall;
    sts.two      = two;
  end

endmodule
`default_nettype wire

// ===== src/grid_line_spacing_classifier_top.sv =====
// Top level of the grid line spacing classifier.
// Depends on glsc_pkg, glsc_ctrl and glsc_dp.
`timescale 1ns / 1ps
`default_nettype none
// Points (position, line_id) are taken one transaction per cycle while the block
// is loading; up to 64 are stored and later ones are dropped, though a dropped
// point with last set still closes the set. After the last point the input is
// stalled while the block works through n points: a stable rank sort of the
// points, gap forming, a rank sort of the n-1 gaps, the window search, and
// window selection, each by read sweeps over the on-chip memories. Results then
// leave through a registered output, one per cycle while not stalled: either ten
// groups of line ids (one or two results per group, duplicates dropped, lower id
// first) or a single fail result with found low. final_res marks the last result
// of a run. Configuration writes (min_spacing at index 0, max_ratio_tenths at
// index 1) are taken at any time but belong between runs.
module grid_line_spacing_classifier_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] position,
  input  wire logic [7:0]  line_id,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [3:0]       group,
  output logic [7:0]       member_id,
  output logic             final_res
);

  glsc_pkg::cmd_t cmd;
  glsc_pkg::sts_t sts;

  // The controller sequences every phase; the datapath holds all storage.
  glsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  glsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .position  (position),
    .line_id   (line_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .group     (group),
    .member_id (member_id),
    .final_res (final_res)
  );

`ifndef SYNTHESIS
  // A fail result always stands alone and carries zero fields.
  a_fail_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (final_res && group == 4'd0 && member_id == 8'd0))
    else $error("fail result malformed");

  // Group indexes never pass the last grid line.
  a_group_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (group <= glsc_pkg::LAST_GRP))
    else $error("group index out of range");

  // Only the last grid line can close a found run.
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found && final_res) |-> (group == glsc_pkg::LAST_GRP))
    else $error("final result before last group");
`endif

endmodule
`default_nettype wire
